// ===== rtl/fcrc_pkg.sv =====
package fcrc_pkg;

    // CRC-16 generator polynomial, bits fed LSB first, no reflection of the result
    localparam logic [15:0] CRC_POLY = 16'h8005;

    // Smallest legal count byte: the count itself plus two CRC bytes
    localparam logic [7:0] MIN_COUNT = 8'd3;

    typedef struct packed {
        logic       cmd;
        logic [7:0] data_byte;
    } in_word_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       is_crc_byte;
        logic       frame_end;
        logic       crc_ok;
        logic       length_error;
    } out_word_t;

    // Frame tracking state carried from word to word
    typedef struct packed {
        logic [15:0] crc_value;
        logic [7:0]  frame_length;
        logic [7:0]  byte_index;
        logic        in_frame;
        logic        check_mode;
        logic        low_match;
    } frame_state_t;

    // Generated CRC bytes still to be sent after the last covered word
    typedef enum logic [1:0] {
        TAIL_NONE,
        TAIL_LOW,
        TAIL_HIGH
    } tail_state_t;

    // Eight-bit CRC update, one data bit per step, LSB first
    function automatic logic [15:0] crc_feed(input logic [15:0] crc_in,
                                             input logic [7:0]  data_in);
        logic [15:0] c;
        c = crc_in;
        for (int k = 0; k < 8; k++)
        begin
            if (data_in[k] ^ c[15])
            begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end
            else
            begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

// ===== rtl/fcrc_step.sv =====
module fcrc_step
    import fcrc_pkg::*;
(
    input  frame_state_t st,
    input  in_word_t     word,
    output frame_state_t st_next,
    output out_word_t    res,
    output logic         tail_start
);

    frame_state_t base;
    logic [8:0]   idx_ext;
    logic [8:0]   len_ext;
    logic         short_count;

    // Count byte opens a new frame; a short count is flagged and leaves state alone
    always_comb
    begin
        short_count = 1'b0;
        base        = st;
        if (!st.in_frame)
        begin
            if (word.data_byte < MIN_COUNT)
            begin
                short_count = 1'b1;
            end
            else
            begin
                base.crc_value    = '0;
                base.frame_length = word.data_byte;
                base.byte_index   = '0;
                base.in_frame     = 1'b1;
                base.check_mode   = word.cmd;
                base.low_match    = 1'b0;
            end
        end
    end

    assign idx_ext = {1'b0, base.byte_index};
    assign len_ext = {1'b0, base.frame_length};

    // Classify the word: short count, covered, received CRC low, or received CRC high
    always_comb
    begin
        st_next          = base;
        res.out_byte     = word.data_byte;
        res.is_crc_byte  = 1'b0;
        res.frame_end    = 1'b0;
        res.crc_ok       = 1'b0;
        res.length_error = 1'b0;
        tail_start       = 1'b0;
        if (short_count)
        begin
            st_next          = st;
            res.frame_end    = 1'b1;
            res.length_error = 1'b1;
        end
        else
        begin
            st_next.byte_index = base.byte_index + 8'd1;
            if (idx_ext + 9'd2 < len_ext)
            begin
                st_next.crc_value = crc_feed(base.crc_value, word.data_byte);
                if (!base.check_mode && (idx_ext + 9'd3 == len_ext))
                begin
                    tail_start       = 1'b1;
                    st_next.in_frame = 1'b0;
                end
            end
            else if (idx_ext + 9'd2 == len_ext)
            begin
                st_next.low_match = (word.data_byte == base.crc_value[7:0]);
            end
            else
            begin
                res.frame_end    = 1'b1;
                res.crc_ok       = base.low_match &&
                                   (word.data_byte == base.crc_value[15:8]);
                st_next.in_frame = 1'b0;
            end
        end
    end

endmodule

// ===== rtl/framed_crc16_generate_check.sv =====
// Byte-serial CRC-16 framer and checker (poly 0x8005, init 0, LSB first, not
// reflected). The first byte of each frame is a count N covering the whole frame
// including the two CRC bytes; cmd on that byte picks generate (0) or check (1).
// Each accepted word is loaded as its echo into the output register, and a
// word is taken every cycle while the output side keeps up and no CRC tail is
// pending. In generate mode the last covered byte is followed by the CRC low and
// high bytes: these are sent in turn from the held CRC register, during which
// in_ready is low. A count below 3 is echoed with length_error and frame_end set
// and the block waits for the next count byte.
// In check mode the final word carries frame_end and crc_ok.
module framed_crc16_generate_check
    import fcrc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  in_word_t  in_word,
    output logic      out_valid,
    input  logic      out_ready,
    output out_word_t out_word
);

    frame_state_t state_reg, state_next;
    frame_state_t step_state;
    out_word_t    step_res;
    logic         step_tail;

    tail_state_t  tail_reg, tail_next;
    logic         out_valid_reg, out_valid_next;
    out_word_t    out_word_reg, out_word_next;

    logic         slot_free;
    logic         accept;
    logic         tail_emit;

    fcrc_step u_step (
        .st         (state_reg),
        .word       (in_word),
        .st_next    (step_state),
        .res        (step_res),
        .tail_start (step_tail)
    );

    // Handshake
    assign slot_free = !out_valid_reg || out_ready;
    assign in_ready  = slot_free && (tail_reg == TAIL_NONE);
    assign accept    = in_valid && in_ready;
    assign tail_emit = slot_free && (tail_reg != TAIL_NONE);

    // Tail sequencer: next state
    always_comb
    begin
        tail_next = tail_reg;
        unique case (tail_reg)
            TAIL_NONE:
            begin
                if (accept && step_tail)
                begin
                    tail_next = TAIL_LOW;
                end
            end
            TAIL_LOW:
            begin
                if (slot_free)
                begin
                    tail_next = TAIL_HIGH;
                end
            end
            TAIL_HIGH:
            begin
                if (slot_free)
                begin
                    tail_next = TAIL_NONE;
                end
            end
            default:
            begin
                tail_next = TAIL_NONE;
            end
        endcase
    end

    // Output register load: echo word, or a generated CRC byte
    always_comb
    begin
        out_word_next              = out_word_reg;
        out_word_next.is_crc_byte  = out_word_reg.is_crc_byte;
        out_valid_next             = out_valid_reg && !out_ready;
        if (accept)
        begin
            out_word_next  = step_res;
            out_valid_next = 1'b1;
        end
        else if (tail_emit)
        begin
            out_word_next.is_crc_byte  = 1'b1;
            out_word_next.crc_ok       = 1'b0;
            out_word_next.length_error = 1'b0;
            out_valid_next             = 1'b1;
            unique case (tail_reg)
                TAIL_LOW:
                begin
                    out_word_next.out_byte  = state_reg.crc_value[7:0];
                    out_word_next.frame_end = 1'b0;
                end
                TAIL_HIGH:
                begin
                    out_word_next.out_byte  = state_reg.crc_value[15:8];
                    out_word_next.frame_end = 1'b1;
                end
                default:
                begin
                    out_word_next = out_word_reg;
                end
            endcase
        end
    end

    assign state_next = accept ? step_state : state_reg;

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= '0;
            tail_reg      <= TAIL_NONE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            tail_reg      <= tail_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        out_word_reg <= out_word_next;
    end

    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

`ifndef ASSERT_OFF
    // A generated low CRC byte taken is followed straight away by the high byte
    a_crc_pair: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && out_word.is_crc_byte && !out_word.frame_end)
        |=> (out_valid && out_word.is_crc_byte && out_word.frame_end))
        else $error("CRC high byte did not follow low byte");

    // crc_ok only on a received frame end
    a_ok_at_end: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_word.crc_ok) |-> (out_word.frame_end && !out_word.is_crc_byte))
        else $error("crc_ok outside a check-mode frame end");

    // A short count always closes the frame
    a_lerr_end: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_word.length_error) |-> (out_word.frame_end && !out_word.is_crc_byte))
        else $error("length_error without frame_end");

    // While CRC bytes are pending the frame is already closed
    a_tail_closed: assert property (@(posedge clk) disable iff (!rst_n)
        (tail_reg != TAIL_NONE) |-> !state_reg.in_frame)
        else $error("CRC tail pending inside an open frame");
`endif

endmodule
